FILE: rtl/qba_pkg.sv
// Shared types, widths and constants of the quantile bin assigner.
package qba_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ROW_W       = 20;
  localparam int unsigned ROWS_W      = 21;
  localparam int unsigned BINS_W      = 17;
  localparam int unsigned BIN_W       = 16;
  localparam int unsigned REM_W       = 16;
  localparam int unsigned QUO_W       = 21;
  localparam int unsigned CFG_DATA_W  = 21;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [ROWS_W-1:0] MAX_ROWS        = 21'd1048576;
  localparam logic [BINS_W-1:0] MAX_BIN_LIMIT   = 17'd65536;
  localparam logic [ROWS_W-1:0] RESET_ROWS      = 21'd1;
  localparam logic [BINS_W-1:0] RESET_BIN_LIMIT = 17'd256;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ROWS      = 1'b0,
    CFG_BIN_LIMIT = 1'b1
  } cfg_reg_e;

  // Column sequencer states.
  typedef enum logic [1:0] {
    ST_START,
    ST_DIV,
    ST_RUN
  } col_state_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
  } qba_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]          out_row;
    logic [BIN_W-1:0]          bin_number;
    logic                      border_added;
    logic signed [VALUE_W-1:0] border_value;
    logic                      column_done;
    logic [BINS_W-1:0]         total_bins;
  } qba_result_t;

  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [BINS_W-1:0] divisor;
  } qba_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quotient;
    logic [REM_W-1:0]  remainder;
  } qba_div_rsp_t;

endpackage

FILE: rtl/qba_queue.sv
// Front end: accepts input transfers into a short item queue.
module qba_queue import qba_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  qba_item_t push_item_i,
  output logic      head_valid_o,
  output qba_item_t head_item_o,
  input  logic      pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  qba_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/qba_div.sv
// Restoring divider, one quotient bit per cycle, for the per-column part size.
module qba_div import qba_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  qba_div_req_t req_i,
  output qba_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [BINS_W-1:0] rem_q, rem_d;
  logic [BINS_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [BINS_W:0]   shifted;
  logic [BINS_W:0]   diff;
  logic              fits;

  assign shifted = {rem_q, quo_q[QUO_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = (shifted >= {1'b0, div_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      div_d = req_i.divisor;
      cnt_d = CNT_W'(QUO_W);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[QUO_W-2:0], fits};
      rem_d = fits ? diff[BINS_W-1:0] : shifted[BINS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[REM_W-1:0];

endmodule

FILE: rtl/qba_core.sv
// Back end: column setup, border tracking and bin assignment per row.
module qba_core import qba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ROWS_W-1:0] rows_cfg_i,
  input  logic [BINS_W-1:0] bin_limit_cfg_i,
  input  logic              head_valid_i,
  input  qba_item_t         head_item_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output qba_result_t       res_o,
  input  logic              res_ready_i
);

  col_state_e state_q, state_d;

  logic [ROW_W-1:0]   pos_q, pos_d;
  logic [BINS_W-1:0]  qidx_q, qidx_d;
  logic [ROWS_W-1:0]  nbp_q, nbp_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [VALUE_W-1:0] prev_q, prev_d;
  logic [BINS_W-1:0]  dcnt_q, dcnt_d;
  logic [ROWS_W-1:0]  col_rows_q, col_rows_d;
  logic [BINS_W-1:0]  col_bins_q, col_bins_d;

  logic               out_valid_q, out_valid_d;
  qba_result_t        out_q, out_d;

  qba_div_req_t       div_req;
  qba_div_rsp_t       div_rsp;

  logic [ROWS_W-1:0]  rows_cl;
  logic [BINS_W-1:0]  bins_cl;
  logic [BINS_W-1:0]  bins_use;

  logic               out_free;
  logic               take, kick, load;
  logic               at_border, new_border, is_last, le_prev;
  logic [BINS_W-1:0]  qidx_inc, bin_full, tail_start;
  logic [ROWS_W-1:0]  term;

  qba_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Clamp the registers to their legal ranges, then cap bins by rows.
  always_comb begin
    rows_cl = rows_cfg_i;
    if (rows_cfg_i == '0) begin
      rows_cl = ROWS_W'(1);
    end else if (rows_cfg_i > MAX_ROWS) begin
      rows_cl = MAX_ROWS;
    end
    bins_cl = bin_limit_cfg_i;
    if (bin_limit_cfg_i == '0) begin
      bins_cl = BINS_W'(1);
    end else if (bin_limit_cfg_i > MAX_BIN_LIMIT) begin
      bins_cl = MAX_BIN_LIMIT;
    end
    bins_use = ({4'b0, bins_cl} > rows_cl) ? rows_cl[BINS_W-1:0] : bins_cl;
  end

  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_START: if (head_valid_i) state_d = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_d = ST_RUN;
      ST_RUN:   if (take && is_last) state_d = ST_START;
      default:  state_d = ST_START;
    endcase
  end

  always_comb begin
    kick = 1'b0;
    load = 1'b0;
    take = 1'b0;
    unique case (state_q)
      ST_START: kick = head_valid_i;
      ST_DIV:   load = div_rsp.done;
      ST_RUN:   take = head_valid_i && out_free;
      default: ;
    endcase
  end

  assign pop_o            = take;
  assign div_req.start    = kick;
  assign div_req.dividend = rows_cl;
  assign div_req.divisor  = bins_use;

  // Per-row decisions.
  assign at_border  = ({1'b0, pos_q} == nbp_q);
  assign new_border = (dcnt_q == '0) || (head_item_i.value != prev_q);
  assign le_prev    = (head_item_i.value <= $signed(prev_q));
  assign is_last    = ({1'b0, pos_q} == (col_rows_q - 1'b1));
  assign qidx_inc   = qidx_q + 1'b1;
  assign tail_start = col_bins_q - {1'b0, rem_q};
  assign term       = quo_q + ROWS_W'(qidx_inc >= tail_start);

  always_comb begin
    pos_d      = pos_q;
    qidx_d     = qidx_q;
    nbp_d      = nbp_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    prev_d     = prev_q;
    dcnt_d     = dcnt_q;
    col_rows_d = col_rows_q;
    col_bins_d = col_bins_q;
    bin_full   = dcnt_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;

    if (kick) begin
      col_rows_d = rows_cl;
      col_bins_d = bins_use;
    end

    if (load) begin
      quo_d  = div_rsp.quotient;
      rem_d  = div_rsp.remainder;
      qidx_d = '0;
      nbp_d  = div_rsp.quotient - 1'b1;
      dcnt_d = '0;
      prev_d = '0;
    end

    if (take) begin
      if (at_border) begin
        if (new_border) begin
          prev_d = head_item_i.value;
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          bin_full = dcnt_q - 1'b1;
        end
        qidx_d = qidx_inc;
        if (qidx_inc < col_bins_q) begin
          nbp_d = nbp_q + term;
        end
      end else if (dcnt_q != '0 && le_prev) begin
        bin_full = dcnt_q - 1'b1;
      end
      pos_d = is_last ? '0 : pos_q + 1'b1;

      out_valid_d        = 1'b1;
      out_d.out_row      = head_item_i.row;
      out_d.bin_number   = bin_full[BIN_W-1:0];
      out_d.border_added = at_border && new_border;
      out_d.border_value = (at_border && new_border) ? head_item_i.value : '0;
      out_d.column_done  = is_last;
      out_d.total_bins   = is_last ? dcnt_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      pos_q       <= '0;
      qidx_q      <= '0;
      nbp_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      prev_q      <= '0;
      dcnt_q      <= '0;
      col_rows_q  <= '0;
      col_bins_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      qidx_q      <= qidx_d;
      nbp_q       <= nbp_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      prev_q      <= prev_d;
      dcnt_q      <= dcnt_d;
      col_rows_q  <= col_rows_d;
      col_bins_q  <= col_bins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: rtl/quantile_bin_assigner.sv
// Top level of the quantile bin assigner: config registers, queue, core and packing.
// A row's result passes through the queue and then the core's output register.
// The first row of each column also waits for the 21-step divider that computes the
// part size and remainder. After that one row completes per cycle while the output is not held.
// Reset (rst_ni low, asynchronous) empties the queue, drops any pending result, starts
// a new column, and sets rows_in_column to 1 and bin_limit to 256.
module quantile_bin_assigner import qba_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel; the address is the register index.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [0:0]             cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: sorted_value [31:0], row_index [51:32], zero pad [55:52].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Output stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: out_row [19:0], bin_number [35:20], border_value [67:36],
  // total_bins [84:68], zero pad [87:85].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tlast: column_done.
  output logic                   m_axis_tlast_o,
  // tuser: border_added.
  output logic                   m_axis_tuser_o
);

  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [BINS_W-1:0] bin_limit_q, bin_limit_d;

  qba_item_t   in_item;
  qba_item_t   head_item;
  logic        head_valid;
  logic        pop;
  qba_result_t res;
  logic        res_valid;

  // Configuration writes are always taken; they only matter at the next column start.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    rows_d      = rows_q;
    bin_limit_d = bin_limit_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ROWS:      rows_d      = cfg_data_i;
        CFG_BIN_LIMIT: bin_limit_d = cfg_data_i[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= RESET_ROWS;
      bin_limit_q <= RESET_BIN_LIMIT;
    end else begin
      rows_q      <= rows_d;
      bin_limit_q <= bin_limit_d;
    end
  end

  assign in_item.value = $signed(s_axis_tdata_i[VALUE_W-1:0]);
  assign in_item.row   = s_axis_tdata_i[VALUE_W+ROW_W-1:VALUE_W];

  // The queue decouples input transfers from the core, which stalls at each column
  // start while the divider runs and whenever the output register is held.
  qba_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(s_axis_tvalid_i),
    .push_ready_o(s_axis_tready_o),
    .push_item_i (in_item),
    .head_valid_o(head_valid),
    .head_item_o (head_item),
    .pop_i       (pop)
  );

  qba_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rows_cfg_i     (rows_q),
    .bin_limit_cfg_i(bin_limit_q),
    .head_valid_i   (head_valid),
    .head_item_i    (head_item),
    .pop_o          (pop),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (m_axis_tready_i)
  );

  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o  = {3'b000, res.total_bins, res.border_value,
                            res.bin_number, res.out_row};
  assign m_axis_tlast_o  = res.column_done;
  assign m_axis_tuser_o  = res.border_added;

endmodule
